// ===== hw/rtl/i2cmbe_pkg.sv =====
`default_nettype none

package i2cmbe_pkg;

   localparam int unsigned DelayWidth = 16;
   localparam int unsigned BitsPerByte = 8;
   localparam logic [DelayWidth-1:0] DelayReset = 16'd250;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_SEND  = 3'd2,
      OP_RECV  = 3'd3,
      OP_ACK   = 3'd4,
      OP_NACK  = 3'd5,
      OP_RACK  = 3'd6
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_ONE  = 4'b0010,
      PH_TWO  = 4'b0100,
      PH_THREE = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       no_ack;
   } res_type;

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_bit_engine_unit.sv =====
// I2C master bit engine. Each beat on the req_ channel is one timebase tick
// carrying an optional command (req_cmd_valid, req_opcode), a transmit byte
// and the sampled SDA level. Every accepted tick yields exactly one rsp_ beat
// with the SCL/SDA drive levels (1 = released), busy, a one-tick done pulse,
// the shift register contents and the last acknowledge sample.
// The sequencer state updates in the cycle a tick is accepted and the result
// is registered into the result register, or into the skid register while
// the receiver stalls; a tick can be accepted every cycle while req_stall is
// low. A result register plus one skid register sit on the output; req_stall
// rises only once both hold results and falls once the receiver takes one.
// csr_wr_en/csr_wr_data set the ticks per bus phase (0 acts as 1); write it
// only while the engine is idle.
// Synchronous reset returns the engine to idle with both lines released,
// the phase length to 250 ticks and empties the output stages.
`default_nettype none

module i2c_master_bit_engine_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd_valid,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic        req_sda_sample,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl_level,
   output logic             rsp_sda_level,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [7:0]       rsp_rx_byte,
   output logic             rsp_no_ack,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic [i2cmbe_pkg::DelayWidth-1:0] delay_ff;

   i2cmbe_pkg::phase_type phase_ff, phase_in;
   i2cmbe_pkg::op_type    cmd_ff, cmd_in;
   logic [i2cmbe_pkg::DelayWidth-1:0] cnt_ff, cnt_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       ack_ff, ack_in;

   logic       accept;
   logic       enter;
   i2cmbe_pkg::phase_type enter_ph;
   logic       done;
   logic [i2cmbe_pkg::DelayWidth-1:0] cnt_dec;
   logic [i2cmbe_pkg::DelayWidth-1:0] delay_eff;
   i2cmbe_pkg::res_type res;

   i2cmbe_pkg::res_type out_ff, out_in, skid_ff, skid_in;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic take;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign cnt_dec   = cnt_ff - {{(i2cmbe_pkg::DelayWidth-1){1'b0}}, 1'b1};
   assign delay_eff = (delay_ff == '0) ? {{(i2cmbe_pkg::DelayWidth-1){1'b0}}, 1'b1}
                                       : delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= i2cmbe_pkg::DelayReset;
      end else if (csr_wr_en) begin
         delay_ff <= csr_wr_data;
      end
   end

   // sequencer next state for one tick
   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      cnt_in   = cnt_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      ack_in   = ack_ff;
      enter    = 1'b0;
      enter_ph = i2cmbe_pkg::PH_ONE;
      done     = 1'b0;

      if (phase_ff != i2cmbe_pkg::PH_IDLE) begin
         cnt_in = cnt_dec;
         if (cnt_dec == '0) begin
            unique case (cmd_ff)
               i2cmbe_pkg::OP_SEND: begin
                  if (phase_ff == i2cmbe_pkg::PH_THREE) begin
                     shift_in = {shift_ff[6:0], 1'b0};
                     bit_in   = bit_ff + 4'd1;
                     if (bit_in[3]) begin
                        done = 1'b1;
                     end else begin
                        enter = 1'b1;
                     end
                  end else begin
                     enter    = 1'b1;
                     enter_ph = (phase_ff == i2cmbe_pkg::PH_ONE) ? i2cmbe_pkg::PH_TWO
                                                                  : i2cmbe_pkg::PH_THREE;
                  end
               end
               i2cmbe_pkg::OP_RECV: begin
                  if (phase_ff == i2cmbe_pkg::PH_ONE) begin
                     shift_in = {shift_ff[6:0], req_sda_sample};
                     enter    = 1'b1;
                     enter_ph = i2cmbe_pkg::PH_TWO;
                  end else begin
                     bit_in = bit_ff + 4'd1;
                     if (bit_in[3]) begin
                        done = 1'b1;
                     end else begin
                        enter = 1'b1;
                     end
                  end
               end
               default: begin
                  if (phase_ff == i2cmbe_pkg::PH_TWO && cmd_ff == i2cmbe_pkg::OP_RACK) begin
                     ack_in = req_sda_sample;
                  end
                  if (phase_ff == i2cmbe_pkg::PH_THREE) begin
                     if (cmd_ff == i2cmbe_pkg::OP_ACK) begin
                        sda_in = 1'b1;
                     end
                     done = 1'b1;
                  end else begin
                     enter    = 1'b1;
                     enter_ph = (phase_ff == i2cmbe_pkg::PH_ONE) ? i2cmbe_pkg::PH_TWO
                                                                  : i2cmbe_pkg::PH_THREE;
                  end
               end
            endcase
            if (done) begin
               phase_in = i2cmbe_pkg::PH_IDLE;
            end
         end
      end else if (req_cmd_valid && req_opcode <= i2cmbe_pkg::OP_RACK) begin
         cmd_in = i2cmbe_pkg::op_type'(req_opcode);
         bit_in = '0;
         if (cmd_in == i2cmbe_pkg::OP_SEND) begin
            shift_in = req_tx_byte;
         end else if (cmd_in == i2cmbe_pkg::OP_RECV) begin
            shift_in = '0;
         end
         enter = 1'b1;
      end

      // phase entry: load the delay and drive the lines
      if (enter) begin
         phase_in = enter_ph;
         cnt_in   = delay_eff;
         unique case (cmd_in)
            i2cmbe_pkg::OP_START: begin
               if (enter_ph == i2cmbe_pkg::PH_ONE) begin
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end else if (enter_ph == i2cmbe_pkg::PH_TWO) begin
                  sda_in = 1'b0;
               end else begin
                  scl_in = 1'b0;
               end
            end
            i2cmbe_pkg::OP_STOP: begin
               if (enter_ph == i2cmbe_pkg::PH_ONE) begin
                  scl_in = 1'b0;
                  sda_in = 1'b0;
               end else if (enter_ph == i2cmbe_pkg::PH_TWO) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in = 1'b1;
               end
            end
            i2cmbe_pkg::OP_SEND: begin
               if (enter_ph == i2cmbe_pkg::PH_ONE) begin
                  sda_in = shift_in[7];
               end else if (enter_ph == i2cmbe_pkg::PH_TWO) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
                  if (bit_in == 4'd7) begin
                     sda_in = 1'b1;
                  end
               end
            end
            i2cmbe_pkg::OP_RECV: begin
               if (enter_ph == i2cmbe_pkg::PH_ONE) begin
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            i2cmbe_pkg::OP_ACK: begin
               if (enter_ph == i2cmbe_pkg::PH_ONE) begin
                  sda_in = 1'b0;
               end else if (enter_ph == i2cmbe_pkg::PH_TWO) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            default: begin
               // nack and receive ack: SDA released for the clock pulse
               if (enter_ph == i2cmbe_pkg::PH_ONE) begin
                  sda_in = 1'b1;
               end else if (enter_ph == i2cmbe_pkg::PH_TWO) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
         endcase
      end

      res.scl_level = scl_in;
      res.sda_level = sda_in;
      res.busy_res  = (phase_in != i2cmbe_pkg::PH_IDLE);
      res.done_res  = done;
      res.rx_byte   = shift_in;
      res.no_ack    = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= i2cmbe_pkg::PH_IDLE;
         cmd_ff   <= i2cmbe_pkg::OP_START;
         cnt_ff   <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         cnt_ff   <= cnt_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ack_ff   <= ack_in;
      end
   end

   // result register with one skid beat behind it
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (take || !out_valid_ff) begin
         out_valid_in  = skid_valid_ff || accept;
         out_in        = skid_valid_ff ? skid_ff : res;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_scl_level = out_ff.scl_level;
   assign rsp_sda_level = out_ff.sda_level;
   assign rsp_busy_res  = out_ff.busy_res;
   assign rsp_done_res  = out_ff.done_res;
   assign rsp_rx_byte   = out_ff.rx_byte;
   assign rsp_no_ack    = out_ff.no_ack;

endmodule

`default_nettype wire
